[design/hrgi_pkg.sv]
// ----------------------------------------------------------------------------
// hrgi_pkg
// Shared types and constants for the heart-rate gap interpolator.
// ----------------------------------------------------------------------------
package hrgi_pkg;

   localparam int RateW    = 8;                  // sample width
   localparam int MaxGap   = 63;                 // longest gap that is repaired
   localparam int CntW     = 6;                  // held-zero counter width
   localparam int DivW     = CntW + 1;           // divisor n = gap + 1
   localparam int NumW     = RateW + CntW;       // interpolation numerator
   localparam int StepCntW = $clog2(RateW + 1);  // divider step counter

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTERP,
      ST_SAMPLE,
      ST_ZERO,
      ST_FLUSH
   } hrgi_state_type;

   typedef struct packed {
      logic [RateW-1:0] rate_out;
      logic             interpolated;
      logic             unrepaired;
      logic             last_of_run;
   } hrgi_result_type;

   typedef struct packed {
      logic             done;
      logic [RateW-1:0] quotient;
   } hrgi_div_status_type;

endpackage

[design/hrgi_div.sv]
// ----------------------------------------------------------------------------
// hrgi_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrgi_div import hrgi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumW-1:0]     dividend,
   input  logic [DivW-1:0]     divisor,
   output hrgi_div_status_type status
);

   logic [DivW-1:0]     rem_ff, rem_in;
   logic [RateW-1:0]    dvd_ff, dvd_in;
   logic [DivW-1:0]     den_ff, den_in;
   logic [StepCntW-1:0] step_ff, step_in;
   logic [DivW:0]       trial;
   logic                ge;

   // quotient fits in RateW bits, so the top bits of the dividend start as
   // the partial remainder and stay below the divisor
   always_comb begin
      trial   = {rem_ff, dvd_ff[RateW-1]};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      step_in = step_ff;
      if (start) begin
         rem_in  = DivW'(dividend[NumW-1:RateW]);
         dvd_in  = dividend[RateW-1:0];
         den_in  = divisor;
         step_in = StepCntW'(RateW);
      end else if (step_ff != '0) begin
         rem_in  = ge ? DivW'(trial - {1'b0, den_ff}) : trial[DivW-1:0];
         dvd_in  = {dvd_ff[RateW-2:0], ge};
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
   end

   assign status.done     = (step_ff == '0);
   assign status.quotient = dvd_ff;

endmodule

[design/hrgi_out_reg.sv]
// ----------------------------------------------------------------------------
// hrgi_out_reg
// Output register for the result channel.
// ----------------------------------------------------------------------------
module hrgi_out_reg import hrgi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hrgi_result_type  result,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hrgi_result_type  rsp_data
);

   logic            valid_ff;
   hrgi_result_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= push;
      end
      if (free && push) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[design/heart_rate_gap_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// heart_rate_gap_interpolator_unit
// Fills heart-rate dropouts by linear interpolation between anchors.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per transaction; a zero rate is a dropout.
//   rsp_* carries the repaired samples; rsp_last_of_run closes the results
//   of one request. A request that only extends a gap yields no result.
//   req_stall is high while a request is being worked on; the next request
//   is taken once the last result of the current one is in the output
//   register, even if the receiver has not taken it yet.
// Sequencing:
//   A sample that closes a gap of g zeros yields g interpolated values and
//   then the sample itself: each interpolated value goes through the
//   bit-serial divider, which forms its 8 quotient bits one after another,
//   and is then handed over. An unrepaired flush emits one result per zero
//   plus one for the request itself.
// Reset:
//   Synchronous, active high; clears the anchor, the held count and the
//   output register. End of record returns the state to the same values.
// Backpressure:
//   rsp_stall holds the output register and pauses the sequencer.
// ----------------------------------------------------------------------------
module heart_rate_gap_interpolator_unit import hrgi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [RateW-1:0] req_heart_rate,
   input  logic             req_end_of_record,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [RateW-1:0] rsp_rate_out,
   output logic             rsp_interpolated,
   output logic             rsp_unrepaired,
   output logic             rsp_last_of_run
);

   hrgi_state_type      state_ff, state_in;

   // model state
   logic [RateW-1:0]    anchor_ff, anchor_in;
   logic                anchor_valid_ff, anchor_valid_in;
   logic [CntW-1:0]     held_ff, held_in;

   // per-transaction work registers
   logic [RateW-1:0]    hr_ff, hr_in;
   logic [RateW-1:0]    start_ff, start_in;
   logic [CntW-1:0]     gap_ff, gap_in;
   logic [CntW-1:0]     idx_ff, idx_in;
   logic [NumW-1:0]     num_ff, num_in;
   logic [DivW-1:0]     flush_left_ff, flush_left_in;

   logic                accept, is_zero, do_interp, more;
   logic [NumW-1:0]     num_first, num_step;
   logic                push, out_free, div_start;
   logic [NumW-1:0]     div_dividend;
   hrgi_result_type     result, rsp_data;
   hrgi_div_status_type div_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_zero   = (req_heart_rate == '0);
   assign do_interp = !is_zero && anchor_valid_ff && (held_ff != '0);
   assign more      = (idx_ff != gap_ff);

   // numerator for position 1 is start*n + (end-start) = start*gap + end;
   // each later position adds end - start
   assign num_first = NumW'(anchor_ff) * NumW'(held_ff) + NumW'(req_heart_rate);
   assign num_step  = num_ff + NumW'(hr_ff) - NumW'(start_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!is_zero) begin
                  state_in = do_interp ? ST_INTERP : ST_SAMPLE;
               end else if (!anchor_valid_ff) begin
                  state_in = ST_ZERO;
               end else if ((held_ff >= CntW'(MaxGap)) || req_end_of_record) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_INTERP: begin
            if (div_status.done && out_free && !more) begin
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE, ST_ZERO: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free && (flush_left_ff == DivW'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      push         = 1'b0;
      result       = '0;
      div_start    = 1'b0;
      div_dividend = num_step;
      case (state_ff)
         ST_IDLE: begin
            div_start    = accept && do_interp;
            div_dividend = num_first;
         end
         ST_INTERP: begin
            if (div_status.done && out_free) begin
               push                = 1'b1;
               result.rate_out     = div_status.quotient;
               result.interpolated = 1'b1;
               div_start           = more;
            end
         end
         ST_SAMPLE: begin
            push               = out_free;
            result.rate_out    = hr_ff;
            result.last_of_run = 1'b1;
         end
         ST_ZERO: begin
            push               = out_free;
            result.last_of_run = 1'b1;
         end
         ST_FLUSH: begin
            push               = out_free;
            result.unrepaired  = 1'b1;
            result.last_of_run = (flush_left_ff == DivW'(1));
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      anchor_in       = anchor_ff;
      anchor_valid_in = anchor_valid_ff;
      held_in         = held_ff;
      hr_in           = hr_ff;
      start_in        = start_ff;
      gap_in          = gap_ff;
      idx_in          = idx_ff;
      num_in          = num_ff;
      flush_left_in   = flush_left_ff;
      if (accept) begin
         hr_in    = req_heart_rate;
         start_in = anchor_ff;
         gap_in   = held_ff;
         idx_in   = CntW'(1);
         num_in   = num_first;
         if (!is_zero) begin
            anchor_in       = req_heart_rate;
            anchor_valid_in = 1'b1;
            held_in         = '0;
         end else if (anchor_valid_ff) begin
            if (held_ff >= CntW'(MaxGap)) begin
               // overflow: flush held zeros plus this one, drop the anchor
               flush_left_in   = DivW'(held_ff) + DivW'(1);
               anchor_in       = '0;
               anchor_valid_in = 1'b0;
               held_in         = '0;
            end else begin
               flush_left_in = DivW'(held_ff) + DivW'(1);
               held_in       = held_ff + 1'b1;
            end
         end
         if (req_end_of_record) begin
            anchor_in       = '0;
            anchor_valid_in = 1'b0;
            held_in         = '0;
         end
      end else if ((state_ff == ST_INTERP) && push) begin
         idx_in = idx_ff + 1'b1;
         num_in = num_step;
      end else if ((state_ff == ST_FLUSH) && push) begin
         flush_left_in = flush_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         anchor_ff       <= '0;
         anchor_valid_ff <= 1'b0;
         held_ff         <= '0;
         flush_left_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         anchor_ff       <= anchor_in;
         anchor_valid_ff <= anchor_valid_in;
         held_ff         <= held_in;
         flush_left_ff   <= flush_left_in;
      end
      hr_ff    <= hr_in;
      start_ff <= start_in;
      gap_ff   <= gap_in;
      idx_ff   <= idx_in;
      num_ff   <= num_in;
   end

   // the first division starts with the request, before gap_ff is loaded
   hrgi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (DivW'(gap_in) + DivW'(1)),
      .status   (div_status)
   );

   hrgi_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_rate_out     = rsp_data.rate_out;
   assign rsp_interpolated = rsp_data.interpolated;
   assign rsp_unrepaired   = rsp_data.unrepaired;
   assign rsp_last_of_run  = rsp_data.last_of_run;

   // gap position stays within 1..gap while interpolating
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INTERP) |-> ((idx_ff != '0) && (idx_ff <= gap_ff)))
      else $error("interpolation index out of range");

   // an interpolated value lies between its two anchors
   a_interp_bounds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_INTERP) && push) |->
         (((div_status.quotient >= start_ff) && (div_status.quotient <= hr_ff)) ||
          ((div_status.quotient <= start_ff) && (div_status.quotient >= hr_ff))))
      else $error("interpolated value outside anchor range");

   // zeros are only held behind a valid anchor
   a_held_anchor: assert property (@(posedge clock) disable iff (reset)
      !anchor_valid_ff |-> (held_ff == '0))
      else $error("held zeros without anchor");

   // a flush never runs with nothing left to emit
   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (flush_left_ff != '0))
      else $error("flush with empty count");

   // the divider is idle whenever a new request is taken
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> div_status.done)
      else $error("divider busy at request");

endmodule

[dv/heart_rate_gap_interpolator_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heart_rate_gap_interpolator_unit_test
// Self-checking bench for the heart-rate gap interpolator. A queue of
// samples feeds a clocked driver. A scoreboard predicts the repaired
// stream for every accepted sample. A monitor checks each result
// transaction in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module heart_rate_gap_interpolator_unit_test import hrgi_pkg::*;;

   localparam int HalfPeriod  = 6;
   localparam int ResetCycles = 9;
   localparam int RandomItems = 256;
   localparam int MaxIdle     = 6;
   localparam int MaxReported = 10;
   localparam int DrainCycles = 9 * MaxGap + 64;
   localparam int CycleLimit  = 3000000;

   typedef struct packed {
      logic [RateW-1:0] heart_rate;
      logic             end_of_record;
   } hr_sample_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [RateW-1:0] req_heart_rate;
   logic             req_end_of_record;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [RateW-1:0] rsp_rate_out;
   logic             rsp_interpolated;
   logic             rsp_unrepaired;
   logic             rsp_last_of_run;

   hr_sample_type   sample_q[$];
   hrgi_result_type repaired_q[$];

   // scoreboard copy of the repair state
   logic [RateW-1:0] anchor_rate;
   logic             anchor_ok;
   logic [CntW-1:0]  held_zeros;

   int sent_cnt, taken_cnt, result_cnt, interp_cnt, unrep_cnt, err_cnt, cycle_cnt;
   int req_gap, rsp_hold;
   bit req_taken, rsp_taken, req_quiet, rsp_quiet;

   heart_rate_gap_interpolator_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_heart_rate    (req_heart_rate),
      .req_end_of_record (req_end_of_record),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rate_out      (rsp_rate_out),
      .rsp_interpolated  (rsp_interpolated),
      .rsp_unrepaired    (rsp_unrepaired),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #HalfPeriod clock = ~clock;

   function automatic void add_sample(input logic [RateW-1:0] rate, input logic eor);
      hr_sample_type s;
      s.heart_rate    = rate;
      s.end_of_record = eor;
      sample_q.push_back(s);
      sent_cnt++;
   endfunction

   // Appends the repaired values that one accepted sample releases.
   function automatic void repair_sample(input hr_sample_type s);
      hrgi_result_type batch[$];
      hrgi_result_type r;
      int n;
      int num;
      if (s.heart_rate != 0) begin
         if (anchor_ok && held_zeros != 0) begin
            n = int'(held_zeros) + 1;
            for (int j = 1; j < n; j++) begin
               num = int'(anchor_rate) * (n - j) + int'(s.heart_rate) * j;
               r = '0;
               r.rate_out     = RateW'(num / n);
               r.interpolated = 1'b1;
               batch.push_back(r);
            end
         end
         r = '0;
         r.rate_out = s.heart_rate;
         batch.push_back(r);
         anchor_rate = s.heart_rate;
         anchor_ok   = 1'b1;
         held_zeros  = '0;
      end else if (!anchor_ok) begin
         r = '0;
         batch.push_back(r);
      end else if (held_zeros >= MaxGap) begin
         // overflow: all held zeros plus this one go out unrepaired
         r = '0;
         r.unrepaired = 1'b1;
         repeat (int'(held_zeros) + 1) batch.push_back(r);
         anchor_rate = '0;
         anchor_ok   = 1'b0;
         held_zeros  = '0;
      end else begin
         held_zeros = held_zeros + 1'b1;
      end
      if (s.end_of_record) begin
         r = '0;
         r.unrepaired = 1'b1;
         repeat (int'(held_zeros)) batch.push_back(r);
         anchor_rate = '0;
         anchor_ok   = 1'b0;
         held_zeros  = '0;
      end
      if (batch.size() != 0) begin
         r = batch.pop_back();
         r.last_of_run = 1'b1;
         batch.push_back(r);
      end
      foreach (batch[i]) repaired_q.push_back(batch[i]);
   endfunction

   // request driver
   always @(negedge clock) begin
      hr_sample_type cur;
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            cur = sample_q.pop_front();
            req_heart_rate    <= cur.heart_rate;
            req_end_of_record <= cur.end_of_record;
            req_valid         <= 1'b1;
            if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
            req_gap = req_quiet ? 0 : $urandom_range(0, MaxIdle);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure: a random hold after each accepted transaction
   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, MaxIdle);
      end else if (rsp_hold > 0 && rsp_valid) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold > 0);
   end

   // scoreboard and monitor
   always @(posedge clock) begin
      hr_sample_type   s;
      hrgi_result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) begin
         s.heart_rate    = req_heart_rate;
         s.end_of_record = req_end_of_record;
         repair_sample(s);
         taken_cnt++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         result_cnt++;
         if (repaired_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MaxReported)
               $display("unexpected result %0d: rate %0d interp %b unrep %b last %b",
                        result_cnt, rsp_rate_out, rsp_interpolated, rsp_unrepaired,
                        rsp_last_of_run);
         end else begin
            want = repaired_q.pop_front();
            if (want.interpolated) interp_cnt++;
            if (want.unrepaired) unrep_cnt++;
            if (rsp_rate_out !== want.rate_out || rsp_interpolated !== want.interpolated ||
                rsp_unrepaired !== want.unrepaired || rsp_last_of_run !== want.last_of_run)
            begin
               err_cnt++;
               if (err_cnt <= MaxReported)
                  $display("mismatch on result %0d: expected rate %0d interp %b unrep %b",
                           result_cnt, want.rate_out, want.interpolated, want.unrepaired,
                           " last %b, got rate %0d interp %b unrep %b last %b",
                           want.last_of_run, rsp_rate_out, rsp_interpolated,
                           rsp_unrepaired, rsp_last_of_run);
            end
         end
      end
   end

   initial begin
      cycle_cnt = 0;
      while (cycle_cnt < CycleLimit) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d of %0d samples taken, %0d results pending",
               cycle_cnt, taken_cnt, sent_cnt, repaired_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int directed_n;
      int kind;
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_heart_rate    = '0;
      req_end_of_record = 1'b0;
      rsp_stall         = 1'b0;
      anchor_rate       = '0;
      anchor_ok         = 1'b0;
      held_zeros        = '0;
      sent_cnt = 0; taken_cnt = 0; result_cnt = 0; interp_cnt = 0; unrep_cnt = 0;
      err_cnt = 0; req_gap = 0; rsp_hold = 0;

      // directed: leading zeros, both gap directions, open gaps at end of record
      add_sample(8'd0, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd255, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd1, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd255, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd0, 1'b1);
      add_sample(8'd0, 1'b1);
      add_sample(8'd128, 1'b1);
      add_sample(8'd0, 1'b0);
      add_sample(8'd85, 1'b0);
      add_sample(8'd0, 1'b1);
      add_sample(8'd170, 1'b0);
      add_sample(8'd170, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd170, 1'b1);
      add_sample(8'd1, 1'b0);
      add_sample(8'd0, 1'b0);
      add_sample(8'd254, 1'b1);
      directed_n = sent_cnt;

      while (sent_cnt < directed_n + RandomItems) begin
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            // anchor, short or medium gap, closing sample
            add_sample(RateW'($urandom_range(1, 255)), 1'b0);
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6))
               add_sample(8'd0, 1'b0);
            add_sample(RateW'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
         end else if (kind < 12) begin
            // gap still open when the record ends
            add_sample(RateW'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(0, 7)) add_sample(8'd0, 1'b0);
            add_sample(8'd0, 1'b1);
         end else if (kind == 12) begin
            // around the longest repairable gap; past it the gap is dumped
            // and the remaining zeros are treated as leading zeros
            add_sample(RateW'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(MaxGap - 3, MaxGap + 3)) add_sample(8'd0, 1'b0);
            add_sample(RateW'($urandom_range(1, 255)), $urandom_range(0, 3) == 0);
         end else if (kind < 15) begin
            // record closes, then zeros with no anchor
            add_sample(RateW'($urandom_range(1, 255)), 1'b1);
            repeat ($urandom_range(1, 3)) add_sample(8'd0, $urandom_range(0, 3) == 0);
         end else begin
            repeat ($urandom_range(1, 8))
               add_sample(($urandom_range(0, 2) == 0) ? 8'd0 :
                                                        RateW'($urandom_range(1, 255)),
                          $urandom_range(0, 15) == 0);
         end
      end

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (taken_cnt < sent_cnt) @(posedge clock);
      while (repaired_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d samples (%0d directed) gave %0d results: %0d interpolated, %0d unrepaired",
               taken_cnt, directed_n, result_cnt, interp_cnt, unrep_cnt);
      $display("%0d cycles, %0d mismatches", cycle_cnt, err_cnt);
      if (err_cnt == 0 && repaired_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
